[rtl/c8re_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8re_pkg
// Shared types and constants of the register-class execute unit: operation
// codes, status codes, beat payloads and the execute-stage interface structs.
// ----------------------------------------------------------------------------
package c8re_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

    localparam int          V_COUNT    = 16;
    localparam logic [3:0]  VF_INDEX   = 4'hF;
    localparam logic [3:0]  V0_INDEX   = 4'h0;
    localparam logic [15:0] PC_RESET   = 16'h0200;
    localparam logic [11:0] FONT_RESET = 12'd80;
    localparam logic [15:0] SKIP_STEP  = 16'd2;

    localparam logic [1:0] CFG_SHIFT_USES_VY = 2'd0;
    localparam logic [1:0] CFG_JUMP_USES_VX  = 2'd1;
    localparam logic [1:0] CFG_FONT_BASE     = 2'd2;

    typedef enum logic [4:0] {
        K_SET, K_ADDIMM, K_COPY, K_OR, K_AND, K_XOR, K_ADD, K_SUBXY, K_SUBYX,
        K_SHR, K_SHL, K_SKEQI, K_SKNEI, K_SKEQR, K_SKNER, K_JUMP, K_JUMPOFF,
        K_CALL, K_RET, K_SETI, K_ADDI, K_FONT, K_RAND, K_GETDLY, K_SETDLY,
        K_SETSND
    } c8re_kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERFLOW,
        ST_UNDERFLOW
    } c8re_status_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  imm_byte;
        logic [11:0] address;
        logic [7:0]  random_byte;
    } c8re_in_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [15:0] index_out;
        logic [7:0]  vx_out;
        logic [7:0]  flag_out;
        logic [1:0]  status;
    } c8re_out_t;

    typedef struct packed {
        logic        shift_uses_vy;
        logic        jump_uses_vx;
        logic [11:0] font_base;
    } c8re_cfg_t;

    typedef struct packed {
        c8re_in_t          item;
        logic [7:0]        vx;
        logic [7:0]        vy;
        logic [7:0]        v0;
        logic [7:0]        vf;
        logic [15:0]       pc;
        logic [15:0]       index;
        logic [7:0]        delay;
        logic [STK_CW-1:0] stk_count;
        logic [15:0]       stk_top;
        c8re_cfg_t         cfg;
    } c8re_ctx_t;

    typedef struct packed {
        logic        vx_wr;
        logic [7:0]  vx_val;
        logic        vf_wr;
        logic [7:0]  vf_val;
        logic [15:0] pc;
        logic [15:0] index;
        logic        delay_wr;
        logic        sound_wr;
        logic        push;
        logic        pop;
        c8re_out_t   res;
    } c8re_upd_t;

endpackage

[rtl/chip8_register_execute.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_register_execute
// Executes decoded register-class instructions against the V registers,
// program counter, index register, return stack and timer values.
// ----------------------------------------------------------------------------
// Path: the input register holds an accepted beat, which is executed into the
// result register. Throughput: 1 beat per cycle while m_ready does not stall
// the result; the execute stage updates all state in one pass.
// Reset: synchronous, active low; clears V registers, index, timers, stack
// count, configuration (font base 80) and sets the program counter to 0x200.
// ----------------------------------------------------------------------------
module chip8_register_execute (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_index,
    input  logic [11:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  c8re_pkg::c8re_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output c8re_pkg::c8re_out_t m_data
);

    c8re_pkg::c8re_cfg_t cfg_reg;

    logic [7:0]  vregs_reg [c8re_pkg::V_COUNT];
    logic [15:0] pc_reg;
    logic [15:0] index_reg;
    logic [7:0]  delay_reg;
    logic [7:0]  sound_reg;

    logic                in_valid_reg;
    c8re_pkg::c8re_in_t  in_reg;
    logic [7:0]          vx_reg;
    logic [7:0]          vy_reg;
    logic [7:0]          vx_next;
    logic [7:0]          vy_next;

    logic                out_valid_reg;
    c8re_pkg::c8re_out_t out_reg;

    logic                exec_fire;
    logic                in_fire;
    c8re_pkg::c8re_ctx_t ctx;
    c8re_pkg::c8re_upd_t upd;

    logic                        stk_push;
    logic                        stk_pop;
    logic [c8re_pkg::STK_CW-1:0] stk_count;
    logic [15:0]                 stk_top;

    assign exec_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || exec_fire;
    assign in_fire   = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shift_uses_vy <= 1'b0;
            cfg_reg.jump_uses_vx  <= 1'b0;
            cfg_reg.font_base     <= c8re_pkg::FONT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                c8re_pkg::CFG_SHIFT_USES_VY: cfg_reg.shift_uses_vy <= cfg_wr_data[0];
                c8re_pkg::CFG_JUMP_USES_VX:  cfg_reg.jump_uses_vx  <= cfg_wr_data[0];
                c8re_pkg::CFG_FONT_BASE:     cfg_reg.font_base     <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // register file read with bypass of the write in flight
    always_comb begin
        vx_next = vregs_reg[s_data.x];
        vy_next = vregs_reg[s_data.y];
        if (exec_fire) begin
            if (upd.vf_wr && s_data.x == c8re_pkg::VF_INDEX) vx_next = upd.vf_val;
            if (upd.vf_wr && s_data.y == c8re_pkg::VF_INDEX) vy_next = upd.vf_val;
            if (upd.vx_wr && s_data.x == in_reg.x) vx_next = upd.vx_val;
            if (upd.vx_wr && s_data.y == in_reg.x) vy_next = upd.vx_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_reg <= s_data;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
        end
    end

    always_comb begin
        ctx.item      = in_reg;
        ctx.vx        = vx_reg;
        ctx.vy        = vy_reg;
        ctx.v0        = vregs_reg[c8re_pkg::V0_INDEX];
        ctx.vf        = vregs_reg[c8re_pkg::VF_INDEX];
        ctx.pc        = pc_reg;
        ctx.index     = index_reg;
        ctx.delay     = delay_reg;
        ctx.stk_count = stk_count;
        ctx.stk_top   = stk_top;
        ctx.cfg       = cfg_reg;
    end

    c8re_exec u_exec (
        .ctx (ctx),
        .upd (upd)
    );

    assign stk_push = exec_fire && upd.push;
    assign stk_pop  = exec_fire && upd.pop;

    c8re_stack u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (stk_push),
        .pop       (stk_pop),
        .push_data (pc_reg),
        .count     (stk_count),
        .top       (stk_top)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < c8re_pkg::V_COUNT; i++) begin
                vregs_reg[i] <= '0;
            end
            pc_reg    <= c8re_pkg::PC_RESET;
            index_reg <= '0;
            delay_reg <= '0;
            sound_reg <= '0;
        end else if (exec_fire) begin
            if (upd.vf_wr && !(upd.vx_wr && in_reg.x == c8re_pkg::VF_INDEX)) begin
                vregs_reg[c8re_pkg::VF_INDEX] <= upd.vf_val;
            end
            if (upd.vx_wr) vregs_reg[in_reg.x] <= upd.vx_val;
            pc_reg    <= upd.pc;
            index_reg <= upd.index;
            if (upd.delay_wr) delay_reg <= vx_reg;
            if (upd.sound_wr) sound_reg <= vx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            out_reg <= upd.res;
        end
    end

    a_stack_push_not_full : assert property (@(posedge aclk) disable iff (!aresetn)
        stk_push |-> stk_count != c8re_pkg::STK_CW'(c8re_pkg::STACK_DEPTH))
        else $error("push on full return stack");

    a_stack_push_pop_excl : assert property (@(posedge aclk) disable iff (!aresetn)
        !(stk_push && stk_pop))
        else $error("push and pop in the same cycle");

    a_overflow_holds_pc : assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && upd.res.status == c8re_pkg::ST_OVERFLOW) |=> pc_reg == $past(pc_reg))
        else $error("program counter changed on stack overflow");

    a_sound_only_on_exec : assert property (@(posedge aclk) disable iff (!aresetn)
        !exec_fire |=> sound_reg == $past(sound_reg))
        else $error("sound value changed without an executed beat");

endmodule

[rtl/c8re_stack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8re_stack
// Return stack memory with a fill count and a registered top-of-stack read
// that is prefetched for the next pop.
// ----------------------------------------------------------------------------
module c8re_stack (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  logic                      pop,
    input  logic [15:0]               push_data,
    output logic [c8re_pkg::STK_CW-1:0] count,
    output logic [15:0]               top
);

    logic [15:0]                   mem [c8re_pkg::STACK_DEPTH];
    logic [c8re_pkg::STK_CW-1:0]   count_reg;
    logic [c8re_pkg::STK_CW-1:0]   count_next;
    logic [c8re_pkg::STK_CW-1:0]   below_top;
    logic [15:0]                   top_reg;

    always_comb begin
        count_next = count_reg;
        if (push) begin
            count_next = count_reg + c8re_pkg::STK_CW'(1);
        end else if (pop) begin
            count_next = count_reg - c8re_pkg::STK_CW'(1);
        end
    end

    assign below_top = count_reg - c8re_pkg::STK_CW'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[count_reg[c8re_pkg::STK_AW-1:0]] <= push_data;
            top_reg <= push_data;
        end else if (pop) begin
            top_reg <= mem[below_top[c8re_pkg::STK_AW-1:0]];
        end
    end

    assign count = count_reg;
    assign top   = top_reg;

endmodule

[rtl/c8re_exec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8re_exec
// Single-pass execute logic: from one instruction and the current state,
// form the state updates and the result beat.
// ----------------------------------------------------------------------------
module c8re_exec (
    input  c8re_pkg::c8re_ctx_t ctx,
    output c8re_pkg::c8re_upd_t upd
);

    c8re_pkg::c8re_in_t item;
    logic [8:0]  add_sum;
    logic [7:0]  shift_src;
    logic [7:0]  off_src;
    logic [6:0]  glyph_off;
    logic [16:0] index_sum;
    logic [15:0] pc_skip;
    logic        stk_full;
    logic        stk_empty;

    assign item      = ctx.item;
    assign add_sum   = {1'b0, ctx.vx} + {1'b0, ctx.vy};
    assign shift_src = ctx.cfg.shift_uses_vy ? ctx.vy : ctx.vx;
    assign off_src   = ctx.cfg.jump_uses_vx ? ctx.vx : ctx.v0;
    // glyph offset = 5 * low nibble
    assign glyph_off = {1'b0, ctx.vx[3:0], 2'b00} + {3'b000, ctx.vx[3:0]};
    assign index_sum = {1'b0, ctx.index} + {9'd0, ctx.vx};
    assign pc_skip   = ctx.pc + c8re_pkg::SKIP_STEP;
    assign stk_full  = (ctx.stk_count == c8re_pkg::STK_CW'(c8re_pkg::STACK_DEPTH));
    assign stk_empty = (ctx.stk_count == '0);

    always_comb begin
        upd          = '0;
        upd.pc       = ctx.pc;
        upd.index    = ctx.index;
        upd.res.status = c8re_pkg::ST_OK;
        case (item.kind)
            c8re_pkg::K_SET: begin
                upd.vx_wr  = 1'b1;
                upd.vx_val = item.imm_byte;
            end
            c8re_pkg::K_ADDIMM: begin
                upd.vx_wr  = 1'b1;
                upd.vx_val = ctx.vx + item.imm_byte;
            end
            c8re_pkg::K_COPY: begin
                upd.vx_wr  = 1'b1;
                upd.vx_val = ctx.vy;
            end
            c8re_pkg::K_OR: begin
                upd.vx_wr  = 1'b1;
                upd.vx_val = ctx.vx | ctx.vy;
            end
            c8re_pkg::K_AND: begin
                upd.vx_wr  = 1'b1;
                upd.vx_val = ctx.vx & ctx.vy;
            end
            c8re_pkg::K_XOR: begin
                upd.vx_wr  = 1'b1;
                upd.vx_val = ctx.vx ^ ctx.vy;
            end
            c8re_pkg::K_ADD: begin
                upd.vf_wr  = 1'b1;
                upd.vf_val = {7'd0, add_sum[8]};
                upd.vx_wr  = 1'b1;
                upd.vx_val = add_sum[7:0];
            end
            c8re_pkg::K_SUBXY: begin
                upd.vf_wr  = 1'b1;
                upd.vf_val = {7'd0, ctx.vx >= ctx.vy};
                upd.vx_wr  = 1'b1;
                upd.vx_val = ctx.vx - ctx.vy;
            end
            c8re_pkg::K_SUBYX: begin
                upd.vf_wr  = 1'b1;
                upd.vf_val = {7'd0, ctx.vy >= ctx.vx};
                upd.vx_wr  = 1'b1;
                upd.vx_val = ctx.vy - ctx.vx;
            end
            c8re_pkg::K_SHR: begin
                upd.vf_wr  = 1'b1;
                upd.vf_val = {7'd0, shift_src[0]};
                upd.vx_wr  = 1'b1;
                upd.vx_val = {1'b0, shift_src[7:1]};
            end
            c8re_pkg::K_SHL: begin
                upd.vf_wr  = 1'b1;
                upd.vf_val = {7'd0, shift_src[7]};
                upd.vx_wr  = 1'b1;
                upd.vx_val = {shift_src[6:0], 1'b0};
            end
            c8re_pkg::K_SKEQI: begin
                if (ctx.vx == item.imm_byte) upd.pc = pc_skip;
            end
            c8re_pkg::K_SKNEI: begin
                if (ctx.vx != item.imm_byte) upd.pc = pc_skip;
            end
            c8re_pkg::K_SKEQR: begin
                if (ctx.vx == ctx.vy) upd.pc = pc_skip;
            end
            c8re_pkg::K_SKNER: begin
                if (ctx.vx != ctx.vy) upd.pc = pc_skip;
            end
            c8re_pkg::K_JUMP: begin
                upd.pc = {4'd0, item.address};
            end
            c8re_pkg::K_JUMPOFF: begin
                upd.pc = {4'd0, item.address} + {8'd0, off_src};
            end
            c8re_pkg::K_CALL: begin
                if (stk_full) begin
                    upd.res.status = c8re_pkg::ST_OVERFLOW;
                end else begin
                    upd.push = 1'b1;
                    upd.pc   = {4'd0, item.address};
                end
            end
            c8re_pkg::K_RET: begin
                if (stk_empty) begin
                    upd.res.status = c8re_pkg::ST_UNDERFLOW;
                end else begin
                    upd.pop = 1'b1;
                    upd.pc  = ctx.stk_top;
                end
            end
            c8re_pkg::K_SETI: begin
                upd.index = {4'd0, item.address};
            end
            c8re_pkg::K_ADDI: begin
                upd.index = index_sum[15:0];
                if (index_sum[16]) begin
                    upd.vf_wr  = 1'b1;
                    upd.vf_val = 8'd1;
                end
            end
            c8re_pkg::K_FONT: begin
                upd.index = {4'd0, ctx.cfg.font_base} + {9'd0, glyph_off};
            end
            c8re_pkg::K_RAND: begin
                upd.vx_wr  = 1'b1;
                upd.vx_val = item.random_byte & item.imm_byte;
            end
            c8re_pkg::K_GETDLY: begin
                upd.vx_wr  = 1'b1;
                upd.vx_val = ctx.delay;
            end
            c8re_pkg::K_SETDLY: begin
                upd.delay_wr = 1'b1;
            end
            c8re_pkg::K_SETSND: begin
                upd.sound_wr = 1'b1;
            end
            default: begin
            end
        endcase

        upd.res.next_pc   = upd.pc;
        upd.res.index_out = upd.index;
        // flag first, result second
        if (upd.vx_wr) begin
            upd.res.vx_out = upd.vx_val;
        end else if (upd.vf_wr && item.x == c8re_pkg::VF_INDEX) begin
            upd.res.vx_out = upd.vf_val;
        end else begin
            upd.res.vx_out = ctx.vx;
        end
        if (upd.vx_wr && item.x == c8re_pkg::VF_INDEX) begin
            upd.res.flag_out = upd.vx_val;
        end else if (upd.vf_wr) begin
            upd.res.flag_out = upd.vf_val;
        end else begin
            upd.res.flag_out = ctx.vf;
        end
    end

endmodule
